FILE: design/dtc_pkg.sv
// ============================================================================
// dtc_pkg
// Shared types, constants and helpers for the decimal text to cents block.
// ============================================================================
package dtc_pkg;

    // Width of the integer limit register and of the stored integer part.
    localparam int LIMIT_W = 30;
    // Width of the integer part while one more digit is folded in.
    localparam int ACC_W = LIMIT_W + 4;
    // Width of a result value.
    localparam int CENTS_W = 32;

    localparam int FRAC_DIGITS_DEF = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000000);
    localparam logic [CENTS_W-1:0] MAX_MAG = 32'h7FFF_FFFF;

    // Configuration space: one register, index taken from paddr[2].
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_IDX_LIMIT = 1'b0;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Result of one parse step.
    typedef struct packed {
        logic                       hit;
        status_t                    status;
        logic signed [CENTS_W-1:0]  cents;
    } dtc_result_t;

    // Power of ten for small exponents (fraction padding only).
    function automatic int unsigned pow10(input int n);
        int unsigned r;
        r = 1;
        for (int i = 0; i < 3; i++)
        begin
            if (i < n)
            begin
                r = r * 10;
            end
        end
        return r;
    endfunction

endpackage

FILE: design/dtc_in_if.sv
// ============================================================================
// dtc_in_if
// Character channel: one text byte or an end-of-range mark per transaction.
// ============================================================================
interface dtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       range_end;

    modport source (output valid, output char_code, output range_end, input ready);
    modport sink   (input valid, input char_code, input range_end, output ready);
endinterface

FILE: design/dtc_out_if.sv
// ============================================================================
// dtc_out_if
// Result channel: one status and one signed value per transaction.
// ============================================================================
interface dtc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] cents_value;

    modport source (output valid, output status, output cents_value, input ready);
    modport sink   (input valid, input status, input cents_value, output ready);
endinterface

FILE: design/dtc_step.sv
// ============================================================================
// dtc_step
// Combinational parse step: next parser state and optional result for one
// character or end mark.
// ============================================================================
module dtc_step
    import dtc_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    localparam int SCALE  = 10 ** FRAC_DIGITS,
    localparam int FRAC_W = $clog2(SCALE),
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1)
)
(
    input  phase_t              phase,
    input  logic                neg,
    input  logic [LIMIT_W-1:0]  int_acc,
    input  logic [FRAC_W-1:0]   frac_acc,
    input  logic [CNT_W-1:0]    frac_cnt,
    input  logic [LIMIT_W-1:0]  limit,
    input  logic [7:0]          char_code,
    input  logic                range_end,
    output phase_t              phase_next,
    output logic                neg_next,
    output logic [LIMIT_W-1:0]  int_acc_next,
    output logic [FRAC_W-1:0]   frac_acc_next,
    output logic [CNT_W-1:0]    frac_cnt_next,
    output dtc_result_t         res
);

    localparam int SC_W  = $clog2(SCALE + 1);
    localparam int PAD_W = FRAC_W + SC_W;
    localparam int MAG_W = LIMIT_W + SC_W;
    localparam int FN_W  = FRAC_W + 4;

    logic               digit;
    logic [3:0]         dval;
    logic [ACC_W-1:0]   int_new;
    logic               int_over;
    logic [FN_W-1:0]    frac_new;
    logic [FRAC_W-1:0]  frac_pad;
    logic [MAG_W-1:0]   mag;
    dtc_result_t        value_res;
    logic               do_int;

    assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign dval  = char_code[3:0];

    // Next integer part: acc * 10 + digit, as shift and add.
    assign int_new = ACC_W'({int_acc, 3'b000}) + ACC_W'({int_acc, 1'b0}) + ACC_W'(dval);
    assign int_over = int_new > ACC_W'(limit);

    assign frac_new = FN_W'(frac_acc) * FN_W'(10) + FN_W'(dval);

    // Missing fraction digits count as zeros.
    assign frac_pad = FRAC_W'(PAD_W'(frac_acc)
                      * PAD_W'(pow10(FRAC_DIGITS - int'(frac_cnt))));

    assign mag = MAG_W'(int_acc) * MAG_W'(SCALE) + MAG_W'(frac_pad);

    always_comb
    begin
        value_res.hit = 1'b1;
        if (mag > MAG_W'(MAX_MAG))
        begin
            value_res.status = ST_OVERFLOW;
            value_res.cents  = '0;
        end
        else
        begin
            value_res.status = ST_OK;
            value_res.cents  = neg ? -$signed(mag[CENTS_W-1:0])
                                   : $signed(mag[CENTS_W-1:0]);
        end
    end

    always_comb
    begin
        phase_next    = phase;
        neg_next      = neg;
        int_acc_next  = int_acc;
        frac_acc_next = frac_acc;
        frac_cnt_next = frac_cnt;
        res           = '0;
        do_int        = 1'b0;

        if (range_end)
        begin
            case (phase)
                PH_START, PH_SIGN:
                begin
                    res.hit    = 1'b1;
                    res.status = ST_MALFORMED;
                end
                PH_INT, PH_FRAC:
                begin
                    res = value_res;
                end
                default:
                begin
                    res = '0;
                end
            endcase
            phase_next    = PH_START;
            neg_next      = 1'b0;
            int_acc_next  = '0;
            frac_acc_next = '0;
            frac_cnt_next = '0;
        end
        else
        begin
            case (phase)
                PH_START, PH_SIGN:
                begin
                    if (phase == PH_START && char_code == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (!digit)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_MALFORMED;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        do_int = 1'b1;
                    end
                end
                PH_INT:
                begin
                    if (digit)
                    begin
                        do_int = 1'b1;
                    end
                    else if (char_code == CH_POINT)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        res        = value_res;
                        phase_next = PH_DONE;
                    end
                end
                PH_FRAC:
                begin
                    if (digit)
                    begin
                        if (int'(frac_cnt) < FRAC_DIGITS)
                        begin
                            frac_acc_next = frac_new[FRAC_W-1:0];
                            frac_cnt_next = frac_cnt + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res        = value_res;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase;
                end
            endcase

            if (do_int)
            begin
                if (int_over)
                begin
                    res.hit    = 1'b1;
                    res.status = ST_OVERFLOW;
                    phase_next = PH_DONE;
                end
                else
                begin
                    int_acc_next = int_new[LIMIT_W-1:0];
                    phase_next   = PH_INT;
                end
            end
        end
    end

endmodule

FILE: design/decimal_text_to_cents_core.sv
// ============================================================================
// decimal_text_to_cents_core
// Converts the characters of a decimal number into a signed fixed-point
// value in units of 10^-FRAC_DIGITS (hundredths by default).
// ============================================================================
//
//  Channel   Direction  Transaction contents
//  --------  ---------  -----------------------------------------------
//  chars     in         char_code (8b ASCII), range_end (1b end mark)
//  result    out        status (2b: ok/malformed/overflow), cents_value (32b)
//  APB       in         integer_limit at register 0 (byte address 0)
//
//  A character transaction can be accepted in every cycle. It is parsed
//  while it sits in the input register, by one short step (a x10 add, a
//  x10^FRAC_DIGITS multiply-add and compares), and any result it causes is
//  then registered in the output register. A stalled result holds the
//  output register; once the input register is full, input ready drops.
//  Reset clears the parser to the start of a value and the limit to 100000000.
//
// The number syntax is an optional leading minus, one or more integer digits,
// then an optional point with fraction digits. Extra fraction digits are
// dropped and missing ones count as zero. The first byte that is not part of
// the number closes it and produces the result; all bytes after that are
// ignored until the end mark, which rearms the parser. An end mark while a
// number is still open produces its result as well.
// ============================================================================
module decimal_text_to_cents_core
    import dtc_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    dtc_in_if.sink             chars,
    dtc_out_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SCALE  = 10 ** FRAC_DIGITS;
    localparam int FRAC_W = $clog2(SCALE);
    localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);

    // Configuration register.
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;

    // Input register.
    logic               s1_valid_reg;
    logic [7:0]         s1_char_reg;
    logic               s1_end_reg;

    // Parser state.
    phase_t             phase_reg;
    logic               neg_reg;
    logic [LIMIT_W-1:0] int_acc_reg;
    logic [FRAC_W-1:0]  frac_acc_reg;
    logic [CNT_W-1:0]   frac_cnt_reg;

    phase_t             phase_next;
    logic               neg_next;
    logic [LIMIT_W-1:0] int_acc_next;
    logic [FRAC_W-1:0]  frac_acc_next;
    logic [CNT_W-1:0]   frac_cnt_next;
    dtc_result_t        step_res;

    // Output register.
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic signed [CENTS_W-1:0] out_cents_reg;

    logic               out_free;
    logic               s1_advance;

    // ------------------------------------------------------------------
    // APB register access. Writes land on the access phase; the index is
    // the word address bit, so any write outside register 0 is dropped.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_IDX_LIMIT);

    always_comb
    begin
        if (paddr[2] == CFG_IDX_LIMIT)
        begin
            prdata = PDATA_W'(limit_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The output register frees up when empty or when its
    // result is being taken; the input register advances only then, which
    // keeps one transaction per cycle while the sink is ready.
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || result.ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign chars.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s1_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_char_reg <= chars.char_code;
            s1_end_reg  <= chars.range_end;
        end
    end

    // ------------------------------------------------------------------
    // Parse step.
    // ------------------------------------------------------------------
    dtc_step #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_step (
        .phase         (phase_reg),
        .neg           (neg_reg),
        .int_acc       (int_acc_reg),
        .frac_acc      (frac_acc_reg),
        .frac_cnt      (frac_cnt_reg),
        .limit         (limit_reg),
        .char_code     (s1_char_reg),
        .range_end     (s1_end_reg),
        .phase_next    (phase_next),
        .neg_next      (neg_next),
        .int_acc_next  (int_acc_next),
        .frac_acc_next (frac_acc_next),
        .frac_cnt_next (frac_cnt_next),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            neg_reg      <= 1'b0;
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
        end
        else if (s1_advance)
        begin
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            frac_cnt_reg <= frac_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Characters that close nothing simply leave it empty.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && step_res.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && step_res.hit)
        begin
            out_status_reg <= step_res.status;
            out_cents_reg  <= step_res.cents;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.cents_value = out_cents_reg;

endmodule

FILE: design/dtc_checker.sv
// ============================================================================
// dtc_checker
// Port-level checks for decimal_text_to_cents_core, attached by bind.
// ============================================================================
module dtc_checker
    import dtc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [31:0] cents_value,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata
);

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cents_value))
        else $error("result changed while stalled");

    // Error results carry a zero value, and no undefined status code appears.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MALFORMED || status == ST_OVERFLOW) |-> cents_value == 0)
        else $error("error result with nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_MALFORMED || status == ST_OVERFLOW))
        else $error("undefined status code");

    // Nothing is presented in the cycle after reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // The limit register reads back what was written.
    a_limit_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == CFG_IDX_LIMIT
        |=> (paddr[2] != CFG_IDX_LIMIT) || (psel && penable && pwrite)
            || prdata == {2'b00, $past(pwdata[LIMIT_W-1:0])})
        else $error("limit register readback mismatch");

endmodule

bind decimal_text_to_cents_core dtc_checker u_dtc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .cents_value (result.cents_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

FILE: tb/sv/tb_decimal_text_to_cents_core.sv
// ============================================================================
// tb_decimal_text_to_cents_core
// Self-checking testbench for the decimal text to cents parser. A short
// directed table runs first, then random numbers under several integer limits.
// Results are checked against typed-in values or a parser model in this file.
// ============================================================================
module tb_decimal_text_to_cents_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dtc_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants.
    // ------------------------------------------------------------------------
    localparam int FRAC_DIGITS   = FRAC_DIGITS_DEF;
    // Random character transactions that reach the parser (ignored bytes
    // after a closed number are not counted).
    localparam int RANDOM_ITEMS  = 1750;
    // From this many random transactions on, neither side idles any more.
    localparam int CALM_FROM     = 1500;
    // Random transactions between two integer limit settings.
    localparam int PHASE_ITEMS   = 250;
    // A byte that closes nothing can still be in flight when the last
    // expected result has arrived, so the drain waits on after that.
    localparam int DRAIN_CYCLES  = 8;
    // Upper bound on the run length; leave a wide margin.
    localparam int CYCLE_LIMIT   = 400000;
    // Register 0 (integer_limit) sits at byte address 0.
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {CFG_IDX_LIMIT, 2'b00};

    // ------------------------------------------------------------------------
    // Types.
    // ------------------------------------------------------------------------
    // How a directed row is checked. A row either takes its expectation from
    // the parser model, carries a hand-written result, is known to produce
    // nothing, or is not a character at all but a new integer limit.
    typedef enum int {
        ROW_PREDICT,
        ROW_GIVEN,
        ROW_SILENT,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        status_t                   status;
        logic signed [CENTS_W-1:0] cents;
    } cents_exp_t;

    // For a ROW_LIMIT row, value holds the new integer limit; otherwise it is
    // the expected cents of a ROW_GIVEN row.
    typedef struct {
        row_kind_t                 kind;
        logic [7:0]                char_code;
        logic                      range_end;
        status_t                   status;
        logic signed [CENTS_W-1:0] value;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block.
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    dtc_in_if  chars_if ();
    dtc_out_if result_if ();

    decimal_text_to_cents_core #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Parser model state. It mirrors the block: where the parse stands, the
    // sign, the integer and fraction parts seen so far, and the limit.
    // ------------------------------------------------------------------------
    phase_t             cur_phase  = PH_START;
    bit                 neg_flag   = 1'b0;
    logic [ACC_W-1:0]   int_part   = '0;
    int unsigned        frac_part  = 0;
    int unsigned        frac_count = 0;
    logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;

    // Results still owed by the block, oldest first.
    cents_exp_t pending_cents[$];

    // Bookkeeping.
    int n_errors       = 0;
    int n_sent         = 0;
    int n_counted      = 0;
    int n_results      = 0;
    int n_ok           = 0;
    int n_malformed    = 0;
    int n_overflow     = 0;
    int n_limit_writes = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;

    // Directed table. Results are typed in where they are obvious: empty
    // values, the sign alone, negative zero, a point with no fraction digits,
    // a non-digit where a digit is due, and both kinds of overflow. The row
    // with extra fraction digits is left to the model.
    stim_row_t directed_rows[] = '{
        // Empty value: end mark at the start of a value.
        '{ROW_GIVEN,  8'h00,    1'b1, ST_MALFORMED, 0},
        // End mark right after the minus sign.
        '{ROW_SILENT, CH_MINUS, 1'b0, ST_OK,        0},
        '{ROW_GIVEN,  "*",      1'b1, ST_MALFORMED, 0},
        // Negative zero is a plain zero.
        '{ROW_SILENT, CH_MINUS, 1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_GIVEN,  8'hFF,    1'b1, ST_OK,        0},
        // "5." closed by a comma is 5.00; the end mark after it only rearms.
        '{ROW_SILENT, "5",      1'b0, ST_OK,        0},
        '{ROW_SILENT, CH_POINT, 1'b0, ST_OK,        0},
        '{ROW_GIVEN,  ",",      1'b0, ST_OK,        500},
        '{ROW_SILENT, "7",      1'b1, ST_OK,        0},
        // Top character code where a digit is due; the bytes after it are
        // ignored up to the end mark.
        '{ROW_GIVEN,  8'hFF,    1'b0, ST_MALFORMED, 0},
        '{ROW_SILENT, 8'h00,    1'b0, ST_OK,        0},
        '{ROW_SILENT, 8'h00,    1'b1, ST_OK,        0},
        // Extra fraction digit is dropped, not rounded.
        '{ROW_PREDICT, "7",      1'b0, ST_OK,       0},
        '{ROW_PREDICT, CH_POINT, 1'b0, ST_OK,       0},
        '{ROW_PREDICT, "0",      1'b0, ST_OK,       0},
        '{ROW_PREDICT, "5",      1'b0, ST_OK,       0},
        '{ROW_PREDICT, "9",      1'b0, ST_OK,       0},
        '{ROW_PREDICT, "9",      1'b1, ST_OK,       0},
        // Limit of zero: the first nonzero digit overflows at once.
        '{ROW_LIMIT,  8'h00,    1'b0, ST_OK,        0},
        '{ROW_GIVEN,  "1",      1'b0, ST_OVERFLOW,  0},
        '{ROW_SILENT, CH_POINT, 1'b1, ST_OK,        0},
        // Largest limit: 30000000 passes the limit but 3e9 hundredths does
        // not fit in 31 bits of magnitude.
        '{ROW_LIMIT,  8'h00,    1'b0, ST_OK,        999999999},
        '{ROW_SILENT, "3",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_SILENT, "0",      1'b0, ST_OK,        0},
        '{ROW_GIVEN,  8'h00,    1'b1, ST_OVERFLOW,  0}
    };

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per problem, and a count.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        $display("MISMATCH at %0t: %s, expected %0d, got %0d", $time, what, exp_v, got_v);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // Parser model.
    // ------------------------------------------------------------------------
    // Scales the open number to hundredths (or whatever FRAC_DIGITS gives).
    // Missing fraction digits are padded with zeros. A magnitude that does
    // not fit in 31 bits is an overflow rather than a wrapped value.
    task automatic close_value(output status_t st, output logic signed [CENTS_W-1:0] val);
        longint unsigned frac;
        longint unsigned scale;
        longint unsigned mag;
        frac  = frac_part;
        scale = 1;
        for (int i = 0; i < FRAC_DIGITS; i++)
        begin
            scale = scale * 10;
        end
        for (int c = frac_count; c < FRAC_DIGITS; c++)
        begin
            frac = frac * 10;
        end
        mag = longint'(int_part) * scale + frac;
        if (mag > MAX_MAG)
        begin
            st  = ST_OVERFLOW;
            val = '0;
        end
        else
        begin
            st  = ST_OK;
            val = CENTS_W'(neg_flag ? (64'd0 - mag) : mag);
        end
    endtask

    task automatic clear_number();
        neg_flag   = 1'b0;
        int_part   = '0;
        frac_part  = 0;
        frac_count = 0;
    endtask

    // Folds one character transaction into the model. hit says whether the
    // transaction closes a value and so owes a result.
    task automatic parse_char(input logic [7:0] c, input logic at_end, output bit hit,
                              output status_t st, output logic signed [CENTS_W-1:0] val);
        bit         is_digit;
        logic [3:0] d;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d        = 4'(c - CH_ZERO);
        hit      = 1'b0;
        st       = ST_OK;
        val      = '0;

        if (at_end)
        begin
            // An end mark closes whatever is open and rearms the parser. After
            // a closed number it produces nothing.
            if (cur_phase inside {PH_START, PH_SIGN})
            begin
                hit = 1'b1;
                st  = ST_MALFORMED;
            end
            else if (cur_phase inside {PH_INT, PH_FRAC})
            begin
                hit = 1'b1;
                close_value(st, val);
            end
            cur_phase = PH_START;
            clear_number();
        end
        else if (cur_phase == PH_START && c == CH_MINUS)
        begin
            neg_flag  = 1'b1;
            cur_phase = PH_SIGN;
        end
        else if (cur_phase inside {PH_START, PH_SIGN} && !is_digit)
        begin
            hit       = 1'b1;
            st        = ST_MALFORMED;
            cur_phase = PH_DONE;
        end
        else if (cur_phase inside {PH_START, PH_SIGN, PH_INT})
        begin
            // A first digit lands here too and opens the integer part.
            cur_phase = PH_INT;
            if (is_digit)
            begin
                int_part = int_part * 10 + d;
                if (int_part > limit_reg)
                begin
                    hit       = 1'b1;
                    st        = ST_OVERFLOW;
                    cur_phase = PH_DONE;
                end
            end
            else if (c == CH_POINT)
            begin
                cur_phase = PH_FRAC;
            end
            else
            begin
                hit = 1'b1;
                close_value(st, val);
                cur_phase = PH_DONE;
            end
        end
        else if (cur_phase == PH_FRAC)
        begin
            if (is_digit)
            begin
                if (frac_count < FRAC_DIGITS)
                begin
                    frac_part  = frac_part * 10 + d;
                    frac_count = frac_count + 1;
                end
            end
            else
            begin
                hit = 1'b1;
                close_value(st, val);
                cur_phase = PH_DONE;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Character channel driver.
    // ------------------------------------------------------------------------
    // Sends one character transaction, with an occasional idle burst before
    // it, and books the expectation once the block has taken it.
    task automatic send_char(input logic [7:0] c, input logic at_end,
                             input row_kind_t kind, input cents_exp_t given);
        bit                        hit;
        status_t                   st;
        logic signed [CENTS_W-1:0] val;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        chars_if.range_end <= at_end;
        do
        begin
            @(posedge clk);
        end
        while (chars_if.ready !== 1'b1);

        n_sent++;
        if (at_end || cur_phase != PH_DONE)
        begin
            n_counted++;
        end
        parse_char(c, at_end, hit, st, val);
        case (kind)
            ROW_PREDICT:
            begin
                if (hit)
                begin
                    pending_cents.push_back('{st, val});
                end
            end
            ROW_GIVEN:
            begin
                pending_cents.push_back(given);
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------------
    // Stops the character stream, lets every owed result come back and any
    // silent byte run through, then writes the limit and reads it back.
    task automatic write_limit(input logic [LIMIT_W-1:0] new_limit);
        chars_if.valid <= 1'b0;
        while (pending_cents.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Write: setup cycle, then access cycle until pready.
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(new_limit);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);

        // Read back straight away; psel stays high into the new setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (prdata !== PDATA_W'(new_limit))
        begin
            report_mismatch("integer_limit read back", new_limit, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;

        limit_reg = new_limit;
        n_limit_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // The limit for each random phase: both extremes, the reset value, small
    // limits that overflow often, and limits right at the point where the
    // scaled magnitude stops fitting in 31 bits.
    function automatic logic [LIMIT_W-1:0] phase_limit(input int idx);
        case (idx % 6)
            0:       return LIMIT_W'(999999999);
            1:       return '0;
            2:       return LIMIT_W'($urandom_range(0, 999));
            3:       return LIMIT_RESET;
            4:       return LIMIT_W'($urandom_range(0, 999999999));
            default: return LIMIT_W'($urandom_range(21474836, 21474838));
        endcase
    endfunction

    // Builds one value and sends it. Most values are well formed with random
    // digits; the rest are broken numbers and plain noise. Each entry of the
    // text queue is {end mark, character}.
    task automatic send_random_value();
        logic [8:0] text[$];
        string      lim_txt;
        int         pick;
        int         ndig;
        cents_exp_t none;
        none = '{ST_OK, '0};
        pick = $urandom_range(0, 99);

        if (pick < 75)
        begin
            if ($urandom_range(0, 1))
            begin
                text.push_back({1'b0, CH_MINUS});
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // Integer part equal to the limit or one above it.
                lim_txt = $sformatf("%0d", longint'(limit_reg) + $urandom_range(0, 1));
                foreach (lim_txt[i])
                begin
                    text.push_back({1'b0, lim_txt[i]});
                end
            end
            else
            begin
                ndig = ($urandom_range(0, 6) == 0) ? $urandom_range(7, 10)
                                                   : $urandom_range(1, 6);
                repeat (ndig) text.push_back({1'b0, rand_digit()});
            end
            if ($urandom_range(0, 9) < 6)
            begin
                text.push_back({1'b0, CH_POINT});
                repeat ($urandom_range(0, 4)) text.push_back({1'b0, rand_digit()});
            end
            if ($urandom_range(0, 1))
            begin
                // Closed by a stray byte, followed by bytes that are ignored.
                text.push_back({1'b0, non_digit()});
                repeat ($urandom_range(0, 3)) text.push_back({1'b0, 8'($urandom_range(0, 255))});
            end
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                end
                1:
                begin
                    text.push_back({1'b0, CH_MINUS});
                end
                2:
                begin
                    text.push_back({1'b0, CH_MINUS});
                    text.push_back({1'b0, non_digit()});
                    repeat ($urandom_range(0, 3)) text.push_back({1'b0, 8'($urandom_range(0, 255))});
                end
                default:
                begin
                    text.push_back({1'b0, non_digit()});
                    repeat ($urandom_range(0, 3)) text.push_back({1'b0, 8'($urandom_range(0, 255))});
                end
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 6)) text.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        // The end mark carries a random, ignored character.
        text.push_back({1'b1, 8'($urandom_range(0, 255))});

        foreach (text[i])
        begin
            send_char(text[i][7:0], text[i][8], ROW_PREDICT, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall bursts, with long stretches of ready.
    // ------------------------------------------------------------------------
    initial
    begin
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transaction against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        cents_exp_t exp_item;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_cents.size() == 0)
            begin
                report_mismatch("result with nothing owed, status", -1, result_if.status);
            end
            else
            begin
                exp_item = pending_cents.pop_front();
                n_results++;
                case (exp_item.status)
                    ST_OK:        n_ok++;
                    ST_MALFORMED: n_malformed++;
                    default:      n_overflow++;
                endcase
                if (result_if.status !== exp_item.status)
                begin
                    report_mismatch("status", exp_item.status, result_if.status);
                end
                if (result_if.cents_value !== exp_item.cents)
                begin
                    report_mismatch("cents_value", exp_item.cents, result_if.cents_value);
                end
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results still owed.",
                     cycle_count, pending_cents.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int random_base;
        int next_cfg;
        int cfg_phase;
        int n_directed;
        cents_exp_t given;

        chars_if.valid     <= 1'b0;
        chars_if.char_code <= '0;
        chars_if.range_end <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        rst_n              <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, starting from the reset limit.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LIMIT)
            begin
                write_limit(LIMIT_W'(directed_rows[i].value));
            end
            else
            begin
                given = '{directed_rows[i].status, directed_rows[i].value};
                send_char(directed_rows[i].char_code, directed_rows[i].range_end,
                          directed_rows[i].kind, given);
            end
        end
        n_directed = n_sent;

        // Random part, one integer limit per phase. The limit is only
        // changed between values, once the block has gone quiet.
        random_base = n_counted;
        next_cfg    = 0;
        cfg_phase   = 0;
        while (n_counted - random_base < RANDOM_ITEMS)
        begin
            if (n_counted - random_base >= next_cfg)
            begin
                write_limit(phase_limit(cfg_phase));
                cfg_phase++;
                next_cfg += PHASE_ITEMS;
            end
            calm = (n_counted - random_base) >= CALM_FROM;
            send_random_value();
        end
        chars_if.valid <= 1'b0;

        // Drain: every owed result, then a wait for anything stray.
        while (pending_cents.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d character transactions (%0d directed) and %0d results.",
                 n_sent, n_directed, n_results);
        $display("Results: %0d ok, %0d malformed, %0d overflow, under %0d limit settings.",
                 n_ok, n_malformed, n_overflow, n_limit_writes);
        if (n_errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/dtc_pkg.sv
design/dtc_in_if.sv
design/dtc_out_if.sv
design/dtc_step.sv
design/decimal_text_to_cents_core.sv
design/dtc_checker.sv
tb/sv/tb_decimal_text_to_cents_core.sv
